### rtl/scope_frame_crc16_encoder_defines.svh
// assertion macros shared by the scope frame encoder modules
// needs aclk and aresetn in the scope where a macro is used
`ifndef SCOPE_FRAME_CRC16_ENCODER_DEFINES_SVH
`define SCOPE_FRAME_CRC16_ENCODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define SFCE_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SFCE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/sfce_pkg.sv
// types, constants and the crc byte step for the scope frame encoder
// no dependencies
package sfce_pkg;

    typedef logic [3:0]  byte_idx_t;
    typedef logic [15:0] crc_t;
    typedef logic [63:0] samples_t;

    localparam crc_t      CRC_INIT   = 16'hFFFF;
    localparam crc_t      CRC_POLY   = 16'hA001;
    localparam byte_idx_t DATA_BYTES = 4'd8;
    localparam byte_idx_t CRC_LO_IDX = 4'd8;
    localparam byte_idx_t LAST_IDX   = 4'd9;

    // crc-16/modbus over one byte, lsb first, reflected polynomial
    function automatic crc_t crc_byte(input crc_t crc_in, input logic [7:0] data);
        crc_t c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### rtl/sfce_framer.sv
// serializes one sample set into ten frame words with a running crc
// depends on sfce_pkg and scope_frame_crc16_encoder_defines.svh
`include "scope_frame_crc16_encoder_defines.svh"

module sfce_framer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              ld_valid,
    input  sfce_pkg::samples_t ld_samples,
    output logic              ld_ready,
    output logic [7:0]        m_axis_tdata,  // frame_byte[7:0]
    output logic              m_axis_tlast,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready
);

    logic                act_valid_reg, act_valid_next;
    sfce_pkg::samples_t  data_reg, data_next;
    sfce_pkg::byte_idx_t idx_reg, idx_next;
    sfce_pkg::crc_t      crc_reg, crc_next;
    logic [7:0]          tdata_reg, tdata_next;
    logic                tlast_reg, tlast_next;
    logic                tvalid_reg, tvalid_next;

    logic       out_free;
    logic       emit;
    logic       last_emit;
    logic       ld_take;
    logic [7:0] byte_sel;

    assign out_free  = !tvalid_reg || m_axis_tready;
    assign emit      = out_free && act_valid_reg;
    assign last_emit = emit && (idx_reg == sfce_pkg::LAST_IDX);
    assign ld_ready  = !act_valid_reg || last_emit;
    assign ld_take   = ld_valid && ld_ready;

    // data bytes leave from the bottom of the shifted sample word
    always_comb begin
        if (idx_reg < sfce_pkg::DATA_BYTES) begin
            byte_sel = data_reg[7:0];
        end else if (idx_reg == sfce_pkg::CRC_LO_IDX) begin
            byte_sel = crc_reg[7:0];
        end else begin
            byte_sel = crc_reg[15:8];
        end
    end

    always_comb begin
        act_valid_next = act_valid_reg;
        data_next      = data_reg;
        idx_next       = idx_reg;
        crc_next       = crc_reg;
        if (ld_take) begin
            act_valid_next = 1'b1;
            data_next      = ld_samples;
            idx_next       = '0;
            crc_next       = sfce_pkg::CRC_INIT;
        end else if (last_emit) begin
            act_valid_next = 1'b0;
        end else if (emit) begin
            idx_next  = idx_reg + 4'd1;
            data_next = data_reg >> 8;
            if (idx_reg < sfce_pkg::DATA_BYTES) begin
                crc_next = sfce_pkg::crc_byte(crc_reg, data_reg[7:0]);
            end
        end
    end

    always_comb begin
        tdata_next  = tdata_reg;
        tlast_next  = tlast_reg;
        tvalid_next = tvalid_reg;
        if (emit) begin
            tdata_next  = byte_sel;
            tlast_next  = (idx_reg == sfce_pkg::LAST_IDX);
            tvalid_next = 1'b1;
        end else if (m_axis_tready) begin
            tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_valid_reg <= 1'b0;
            idx_reg       <= '0;
            tvalid_reg    <= 1'b0;
        end else begin
            act_valid_reg <= act_valid_next;
            idx_reg       <= idx_next;
            tvalid_reg    <= tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg  <= data_next;
        crc_reg   <= crc_next;
        tdata_reg <= tdata_next;
        tlast_reg <= tlast_next;
    end

    assign m_axis_tdata  = tdata_reg;
    assign m_axis_tlast  = tlast_reg;
    assign m_axis_tvalid = tvalid_reg;

    `SFCE_ASSERT_IMPL(a_idx_range, act_valid_reg, idx_reg <= sfce_pkg::LAST_IDX,
        "frame index past the last word")
    `SFCE_ASSERT_NEXT(a_load_init, ld_take,
        act_valid_reg && idx_reg == '0 && crc_reg == sfce_pkg::CRC_INIT,
        "new frame did not start from crc init")
    `SFCE_ASSERT_NEXT(a_tlast_out, last_emit, tvalid_reg && tlast_reg,
        "last frame word not marked")
    `SFCE_ASSERT_NEXT(a_idx_step, emit && !last_emit && !ld_take,
        act_valid_reg && idx_reg == $past(idx_reg) + 4'd1,
        "frame index did not advance on a sent word")

endmodule

### rtl/scope_frame_crc16_encoder.sv
// Scope frame encoder, top level.
// Slave channel: one word per sample set, tdata holds four signed 16-bit
// channels, channel_0 in the lowest bits. Master channel: one byte per word,
// ten words per set: each channel low byte then high byte, then the
// crc-16/modbus of those eight bytes, low byte then high byte; tlast marks
// the tenth word.
// The first byte of a frame passes the holding register, the framer sample
// register and the output register; the rest follow one per cycle while
// tready holds. Sample-set throughput is bounded by the byte-wide output port.
// A holding register takes the next set while the current frame is still
// being sent, so s_axis_tready drops only while that register is full.
// The crc advances one byte per sent data byte.
// Reset clears all valid flags; any frame in flight is dropped.
// When the receiver stalls, the output word holds and the frame pauses.
// depends on sfce_pkg, sfce_framer and scope_frame_crc16_encoder_defines.svh
`include "scope_frame_crc16_encoder_defines.svh"

module scope_frame_crc16_encoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [63:0] s_axis_tdata,  // channel_0, channel_1, channel_2, channel_3
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    output logic [7:0]  m_axis_tdata,  // frame_byte[7:0]
    output logic        m_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready
);

    logic               pend_valid_reg, pend_valid_next;
    sfce_pkg::samples_t pend_reg, pend_next;
    logic               s_take;
    logic               ld_ready;

    assign s_axis_tready = !pend_valid_reg;
    assign s_take        = s_axis_tvalid && !pend_valid_reg;

    always_comb begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        if (s_take) begin
            pend_valid_next = 1'b1;
            pend_next       = s_axis_tdata;
        end else if (ld_ready) begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        pend_reg <= pend_next;
    end

    sfce_framer u_framer (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .ld_valid      (pend_valid_reg),
        .ld_samples    (pend_reg),
        .ld_ready      (ld_ready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready)
    );

    `SFCE_ASSERT_NEXT(a_pend_fill, s_take, pend_valid_reg && pend_reg == $past(s_axis_tdata),
        "accepted sample set not held")
    `SFCE_ASSERT_NEXT(a_pend_hold, pend_valid_reg && !ld_ready,
        pend_valid_reg && $stable(pend_reg), "waiting sample set lost")
    `SFCE_ASSERT_NEXT(a_pend_drain, pend_valid_reg && ld_ready, !pend_valid_reg,
        "holding register not freed after hand-off")

endmodule
